// ===== hdl/rcs_pkg.sv =====
// Shared constants and types for the command serializer.
// Used by rcs_bcd_conv and resp_command_serializer_unit; depends on nothing.
package rcs_pkg;

   // Field widths fixed by the channel definition
   localparam int INPUT_BITS     = 32;
   localparam int COUNT_BITS_DEF = 32;
   localparam int REQ_TYPE_W     = 2;

   // Decimal digits that cover any INPUT_BITS value
   localparam int DEC_DIGITS  = 10;
   localparam int DIGIT_IDX_W = 4;

   // Request type codes
   localparam logic [REQ_TYPE_W-1:0] REQ_CMD  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ARG  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DATA = 2'd2;

   // Wire characters
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   typedef struct packed {
      logic                   done;
      logic [DIGIT_IDX_W-1:0] lead_idx;
   } conv_status_type;

endpackage

// ===== hdl/rcs_bcd_conv.sv =====
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on rcs_pkg.
module rcs_bcd_conv
   import rcs_pkg::*;
#(
   parameter int VAL_W = INPUT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VAL_W-1:0]       value,
   input  logic [DIGIT_IDX_W-1:0] digit_sel,
   output logic [3:0]             digit,
   output conv_status_type        status
);

   localparam int CNT_W  = $clog2(VAL_W);
   localparam int BCD_W  = DEC_DIGITS * 4;

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [VAL_W-1:0] bin_ff;
   logic [BCD_W-1:0] bcd_ff;
   logic [BCD_W-1:0] adj;
   logic [BCD_W-1:0] bcd_in;
   logic [DIGIT_IDX_W-1:0] lead;

   // Add 3 to every digit of 5 or more, then shift in the next bit
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
      bcd_in = {adj[BCD_W-2:0], bin_ff[VAL_W-1]};
   end

   // Highest nonzero digit; zero prints as a single digit
   always_comb begin
      lead = '0;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead = DIGIT_IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
      end else if (run_ff && (cnt_ff == CNT_W'(VAL_W - 1))) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         bin_ff <= value;
         bcd_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         bin_ff <= {bin_ff[VAL_W-2:0], 1'b0};
         bcd_ff <= bcd_in;
      end
   end

   assign digit           = bcd_ff[4*digit_sel +: 4];
   assign status.done     = done_ff;
   assign status.lead_idx = lead;

endmodule

// ===== hdl/resp_command_serializer_unit.sv =====
// Top level of the command serializer: sequencer, counters and output register.
// Depends on rcs_pkg and rcs_bcd_conv.
//
//   channel | ports                                             | direction
//   --------+---------------------------------------------------+----------
//   req     | req_valid, req_stall, req_type,                   | in
//           | req_count_or_length, req_data_byte                |
//   rsp     | rsp_valid, rsp_stall, rsp_out_byte,               | out
//           | rsp_last_in_run, rsp_command_done, rsp_sequence_error |
//
// Sequence: a data byte goes out from PH_DATA (then PH_CR2 and PH_LF2 for its
// closing CR LF), an out-of-order item from PH_ERR. A header item emits its
// prefix, then its D decimal digits once the converter is done, then CR LF,
// plus the closing CR LF of an empty argument; the shift-and-add-3 loop of
// rcs_bcd_conv runs over VAL_W = min(COUNT_BITS, 32) bits, one bit per cycle.
// Reset: synchronous, clears counters, sequencer and output valid.
// Stalls: rsp_stall holds the output register; req_stall is high while an
// item is in progress. A new item is taken while the last beat still waits.
module resp_command_serializer_unit
   import rcs_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [INPUT_BITS-1:0] req_count_or_length,
   input  logic [7:0]            req_data_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_in_run,
   output logic                  rsp_command_done,
   output logic                  rsp_sequence_error
);

   localparam int VAL_W = (COUNT_BITS < INPUT_BITS) ? COUNT_BITS : INPUT_BITS;

   // Sequencer codes
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_ERR    = 4'd1;
   localparam logic [3:0] PH_DATA   = 4'd2;
   localparam logic [3:0] PH_PREFIX = 4'd3;
   localparam logic [3:0] PH_DIGIT  = 4'd4;
   localparam logic [3:0] PH_CR1    = 4'd5;
   localparam logic [3:0] PH_LF1    = 4'd6;
   localparam logic [3:0] PH_CR2    = 4'd7;
   localparam logic [3:0] PH_LF2    = 4'd8;

   // Command state
   logic [COUNT_BITS-1:0]  args_ff, args_in;
   logic [COUNT_BITS-1:0]  bytes_ff, bytes_in;
   logic                   inside_ff, inside_in;
   logic [3:0]             phase_ff, phase_in;

   // Per-item working registers
   logic [7:0]             prefix_ff, prefix_in;
   logic [7:0]             data_ff, data_in;
   logic                   tail_ff, tail_in;
   logic                   done_ff, done_in;
   logic                   lead_ld_ff, lead_ld_in;
   logic [DIGIT_IDX_W-1:0] didx_ff, didx_in;

   // Output register
   logic                   out_valid_ff;
   logic [7:0]             out_byte_ff;
   logic                   out_last_ff;
   logic                   out_done_ff;
   logic                   out_err_ff;

   logic                   accept;
   logic                   out_free;
   logic                   emit;
   logic [7:0]             emit_byte;
   logic                   emit_last;
   logic                   emit_done;
   logic                   emit_err;
   logic                   conv_start;
   logic [COUNT_BITS-1:0]  value_c;
   logic [COUNT_BITS-1:0]  args_dec;
   logic [COUNT_BITS-1:0]  bytes_dec;
   logic [DIGIT_IDX_W-1:0] cur_idx;
   logic [3:0]             digit;
   conv_status_type        conv_status;

   assign req_stall = (phase_ff != PH_IDLE);
   assign accept    = req_valid && (phase_ff == PH_IDLE);
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Truncate the count to COUNT_BITS, or widen it with zeros
   assign value_c   = COUNT_BITS'(req_count_or_length[VAL_W-1:0]);
   assign args_dec  = args_ff - 1'b1;
   assign bytes_dec = bytes_ff - 1'b1;

   // First digit comes straight from the leading-digit search
   assign cur_idx   = lead_ld_ff ? didx_ff : conv_status.lead_idx;

   rcs_bcd_conv #(
      .VAL_W(VAL_W)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .value     (req_count_or_length[VAL_W-1:0]),
      .digit_sel (cur_idx),
      .digit     (digit),
      .status    (conv_status)
   );

   always_comb begin
      args_in    = args_ff;
      bytes_in   = bytes_ff;
      inside_in  = inside_ff;
      phase_in   = phase_ff;
      prefix_in  = prefix_ff;
      data_in    = data_ff;
      tail_in    = tail_ff;
      done_in    = done_ff;
      lead_ld_in = lead_ld_ff;
      didx_in    = didx_ff;
      conv_start = 1'b0;
      emit       = 1'b0;
      emit_byte  = '0;
      emit_last  = 1'b0;
      emit_done  = 1'b0;
      emit_err   = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               tail_in    = 1'b0;
               done_in    = 1'b0;
               lead_ld_in = 1'b0;
               data_in    = req_data_byte;
               if (req_type == REQ_CMD && args_ff == '0 && !inside_ff) begin
                  // Begin command: a zero count closes it at the LF
                  args_in    = value_c;
                  done_in    = (value_c == '0);
                  prefix_in  = CHAR_STAR;
                  conv_start = 1'b1;
                  phase_in   = PH_PREFIX;
               end else if (req_type == REQ_ARG && args_ff != '0 && !inside_ff) begin
                  args_in    = args_dec;
                  prefix_in  = CHAR_DOLLAR;
                  conv_start = 1'b1;
                  phase_in   = PH_PREFIX;
                  if (value_c == '0) begin
                     // Empty argument: append its closing CR LF now
                     tail_in = 1'b1;
                     done_in = (args_dec == '0);
                  end else begin
                     bytes_in  = value_c;
                     inside_in = 1'b1;
                  end
               end else if (req_type == REQ_DATA && inside_ff) begin
                  bytes_in = bytes_dec;
                  phase_in = PH_DATA;
                  if (bytes_dec == '0) begin
                     tail_in   = 1'b1;
                     inside_in = 1'b0;
                     done_in   = (args_ff == '0);
                  end
               end else begin
                  // Out of order: drop the item, report one error beat
                  phase_in = PH_ERR;
               end
            end
         end
         PH_ERR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               emit_err  = 1'b1;
               phase_in  = PH_IDLE;
            end
         end
         PH_DATA: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = data_ff;
               emit_last = !tail_ff;
               phase_in  = tail_ff ? PH_CR2 : PH_IDLE;
            end
         end
         PH_PREFIX: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = prefix_ff;
               phase_in  = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            // Wait for the converter, then walk down from the leading digit
            if (out_free && conv_status.done) begin
               emit       = 1'b1;
               emit_byte  = CHAR_ZERO | {4'd0, digit};
               lead_ld_in = 1'b1;
               if (cur_idx == '0) begin
                  phase_in = PH_CR1;
               end else begin
                  didx_in = cur_idx - 1'b1;
               end
            end
         end
         PH_CR1: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CHAR_CR;
               phase_in  = PH_LF1;
            end
         end
         PH_LF1: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CHAR_LF;
               emit_last = !tail_ff;
               emit_done = done_ff && !tail_ff;
               phase_in  = tail_ff ? PH_CR2 : PH_IDLE;
            end
         end
         PH_CR2: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CHAR_CR;
               phase_in  = PH_LF2;
            end
         end
         PH_LF2: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CHAR_LF;
               emit_last = 1'b1;
               emit_done = done_ff;
               phase_in  = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         args_ff      <= '0;
         bytes_ff     <= '0;
         inside_ff    <= 1'b0;
         phase_ff     <= PH_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         args_ff   <= args_in;
         bytes_ff  <= bytes_in;
         inside_ff <= inside_in;
         phase_ff  <= phase_in;
         // Load a new beat, or drop the old one once taken
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: hold while stalled, advance on emit
   always_ff @(posedge clock) begin
      prefix_ff  <= prefix_in;
      data_ff    <= data_in;
      tail_ff    <= tail_in;
      done_ff    <= done_in;
      lead_ld_ff <= lead_ld_in;
      didx_ff    <= didx_in;
      if (emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= emit_last;
         out_done_ff <= emit_done;
         out_err_ff  <= emit_err;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_last_in_run    = out_last_ff;
   assign rsp_command_done   = out_done_ff;
   assign rsp_sequence_error = out_err_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for resp_command_serializer_unit: predicts the serialized byte stream.
// Depends on rcs_pkg for widths, request codes and wire characters; needs only the RTL.
module tb;
   import rcs_pkg::*;

   // Request type 3 has no meaning; the block must reject it.
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   // Settle time after the last expected beat, sized from the header latency.
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_in_run;
      logic       command_done;
      logic       sequence_error;
   } wire_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [INPUT_BITS-1:0] req_count_or_length;
   logic [7:0]            req_data_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last_in_run;
   logic                  rsp_command_done;
   logic                  rsp_sequence_error;

   // Shadow of the serializer's counters, advanced at each accepted request.
   logic [COUNT_BITS_DEF-1:0] args_left;
   logic [COUNT_BITS_DEF-1:0] bytes_left;
   logic                      in_argument;

   // Byte stream still owed by the block, oldest first.
   wire_beat_type expected_stream[$];
   // The newest predicted byte is held back until its run's flags are known.
   wire_beat_type held_beat;
   bit            beat_held;

   int mismatch_count;
   int send_idle_pct;
   int stall_pct;
   int quiet_cycles;

   resp_command_serializer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_count_or_length(req_count_or_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_in_run    (rsp_last_in_run),
      .rsp_command_done   (rsp_command_done),
      .rsp_sequence_error (rsp_sequence_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Stream predictor
   // ---------------------------------------------------------------

   // True when the request kind fits the current framing state.
   function automatic bit in_order(input logic [REQ_TYPE_W-1:0] kind);
      return (kind == REQ_CMD  && args_left == 0 && !in_argument) ||
             (kind == REQ_ARG  && args_left != 0 && !in_argument) ||
             (kind == REQ_DATA && in_argument);
   endfunction

   // Queue the previously held byte and hold this one with clear flags.
   function automatic void stage_byte(input logic [7:0] value);
      if (beat_held) expected_stream.push_back(held_beat);
      held_beat = '{out_byte: value, last_in_run: 1'b0, command_done: 1'b0,
                    sequence_error: 1'b0};
      beat_held = 1'b1;
   endfunction

   function automatic void stage_crlf();
      stage_byte(CHAR_CR);
      stage_byte(CHAR_LF);
   endfunction

   // Emit the decimal text of a count, most significant digit first.
   function automatic void stage_decimal(input logic [COUNT_BITS_DEF-1:0] value);
      logic [7:0]                digits[DEC_DIGITS];
      logic [COUNT_BITS_DEF-1:0] rest;
      int                        k;
      rest = value;
      k = 0;
      do begin
         digits[k] = CHAR_ZERO + 8'(rest % 10);
         rest = rest / 10;
         k++;
      end while (rest != 0);
      for (int i = k - 1; i >= 0; i--) stage_byte(digits[i]);
   endfunction

   // Work out the bytes one accepted request produces and advance the shadow state.
   function automatic void predict_request(input logic [REQ_TYPE_W-1:0] kind,
                                           input logic [INPUT_BITS-1:0] value,
                                           input logic [7:0]            data_val);
      logic done;
      logic rejected;
      done = 1'b0;
      rejected = 1'b0;
      if (!in_order(kind)) begin
         // Out of order: one zero byte flagged as an error, state untouched.
         stage_byte(8'h00);
         rejected = 1'b1;
      end else begin
         case (kind)
            REQ_CMD: begin
               stage_byte(CHAR_STAR);
               stage_decimal(value);
               stage_crlf();
               args_left = value;
               done = (value == 0);
            end
            REQ_ARG: begin
               args_left = args_left - 1;
               stage_byte(CHAR_DOLLAR);
               stage_decimal(value);
               stage_crlf();
               if (value == 0) begin
                  // Empty argument closes at once.
                  stage_crlf();
                  done = (args_left == 0);
               end else begin
                  bytes_left = value;
                  in_argument = 1'b1;
               end
            end
            default: begin
               stage_byte(data_val);
               bytes_left = bytes_left - 1;
               if (bytes_left == 0) begin
                  stage_crlf();
                  in_argument = 1'b0;
                  done = (args_left == 0);
               end
            end
         endcase
      end
      // Flag the final byte of the run and release it.
      held_beat.last_in_run = 1'b1;
      held_beat.command_done = done;
      held_beat.sequence_error = rejected;
      expected_stream.push_back(held_beat);
      beat_held = 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch on %0s at %0t: expected 0x%0h, got 0x%0h", what, $realtime,
               want, got);
      mismatch_count++;
   endtask

   // Compare every accepted output beat with the oldest prediction.
   initial begin
      wire_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_stream.size() == 0) begin
               report_mismatch("unexpected beat, out_byte", 0, rsp_out_byte);
            end else begin
               want = expected_stream.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", want.out_byte, rsp_out_byte);
               if (rsp_last_in_run !== want.last_in_run)
                  report_mismatch("last_in_run", want.last_in_run, rsp_last_in_run);
               if (rsp_command_done !== want.command_done)
                  report_mismatch("command_done", want.command_done, rsp_command_done);
               if (rsp_sequence_error !== want.sequence_error)
                  report_mismatch("sequence_error", want.sequence_error,
                                  rsp_sequence_error);
            end
         end
      end
   end

   // Count cycles in which no beat moves on either channel; end a hung run.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d bytes still owed", quiet_cycles,
                     expected_stream.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Output stall: redraw once per cycle at the falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------

   // Drive one request beat, hold it until accepted, then predict its bytes.
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [INPUT_BITS-1:0] value,
                               input logic [7:0]            data_val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_count_or_length <= value;
      req_data_byte       <= data_val;
      // Hold the beat until the block takes it.
      do @(posedge clock); while (req_stall);
      predict_request(kind, value, data_val);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int stall_rate);
      send_idle_pct = send_pct;
      stall_pct     = stall_rate;
   endtask

   // Hold until every predicted byte has come out.
   task automatic wait_stream_drained();
      while (expected_stream.size() != 0) @(negedge clock);
   endtask

   // Mostly well-formed commands with random content, plus out-of-order noise.
   task automatic send_random_traffic(input int n_items);
      logic [REQ_TYPE_W-1:0] kind;
      logic [INPUT_BITS-1:0] value;
      repeat (n_items) begin
         if ($urandom_range(99) < 12) begin
            // Pick only a kind the block must reject, with random fields.
            do kind = REQ_TYPE_W'($urandom_range(3)); while (in_order(kind));
            send_request(kind, $urandom, 8'($urandom_range(255)));
         end else if (in_argument) begin
            send_request(REQ_DATA, $urandom, 8'($urandom_range(255)));
         end else if (args_left != 0) begin
            value = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(5);
            send_request(REQ_ARG, value, 8'($urandom_range(255)));
         end else begin
            value = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(3);
            send_request(REQ_CMD, value, 8'($urandom_range(255)));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reject everything but a command start straight after reset.
   task automatic test_reject_after_reset();
      send_request(REQ_DATA, 32'h0, 8'h00);
      send_request(REQ_ARG, 32'h5, 8'h11);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF);
   endtask

   // Walk the framing rules: empty command, empty argument, sequence errors inside
   // a command, last-argument completion from a data byte and from an empty argument.
   task automatic test_command_framing();
      send_request(REQ_CMD, 32'd0, 8'h00);
      send_request(REQ_CMD, 32'd2, 8'h00);
      send_request(REQ_CMD, 32'd1, 8'h00);
      send_request(REQ_DATA, 32'd0, 8'h33);
      send_request(REQ_ARG, 32'd0, 8'h00);
      send_request(REQ_ARG, 32'd3, 8'h00);
      send_request(REQ_ARG, 32'd1, 8'h00);
      send_request(REQ_CMD, 32'd1, 8'h00);
      send_request(REQ_DATA, 32'd0, 8'h00);
      send_request(REQ_DATA, 32'd0, 8'hFF);
      send_request(REQ_DATA, 32'd0, 8'h55);
      send_request(REQ_CMD, 32'd1, 8'h00);
      send_request(REQ_ARG, 32'd0, 8'h00);
      send_request(REQ_CMD, 32'd1, 8'h00);
      send_request(REQ_ARG, 32'd1, 8'h00);
      send_request(REQ_DATA, 32'd0, 8'hA5);
   endtask

   // Random commands under each idling pattern.
   task automatic test_random_under_idling();
      set_idling(0, 0);
      send_random_traffic(45);
      set_idling(78, 0);
      send_random_traffic(45);
      set_idling(0, 78);
      send_random_traffic(45);
      set_idling(29, 29);
      send_random_traffic(45);
   endtask

   // Hold off the sender until the stream is empty, then resume, possibly mid-command.
   task automatic test_pause_until_drained();
      set_idling(29, 29);
      send_random_traffic(15);
      release_request();
      wait_stream_drained();
      send_random_traffic(15);
   endtask

   // Full-width count and length. These leave the block waiting on billions of
   // bytes, so run them last.
   task automatic test_full_width_counts();
      set_idling(0, 29);
      // Finish any open command first so the wide count is accepted.
      while (args_left != 0 || in_argument) send_random_traffic(1);
      send_request(REQ_CMD, 32'hFFFF_FFFF, 8'h00);
      send_request(REQ_ARG, 32'd0, 8'h00);
      send_request(REQ_ARG, 32'hFFFF_FFFF, 8'h00);
      send_request(REQ_DATA, 32'h0, 8'h80);
      send_request(REQ_DATA, 32'hFFFF_FFFF, 8'h7F);
      send_request(REQ_CMD, 32'd1, 8'h00);
      send_request(REQ_ARG, 32'd1, 8'h00);
      send_request(REQ_UNUSED, 32'h0, 8'h00);
      send_request(REQ_DATA, 32'h0, 8'h01);
   endtask

   initial begin
      mismatch_count      = 0;
      args_left           = '0;
      bytes_left          = '0;
      in_argument         = 1'b0;
      beat_held           = 1'b0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_type            = REQ_CMD;
      req_count_or_length = '0;
      req_data_byte       = 8'h00;

      // Hold reset high, then drop it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reject_after_reset();
      test_command_framing();
      test_random_under_idling();
      test_pause_until_drained();
      test_full_width_counts();

      // Drain the stream, then give the block time to show any stray beat.
      release_request();
      set_idling(0, 0);
      wait_stream_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rcs_pkg.sv
hdl/rcs_bcd_conv.sv
hdl/resp_command_serializer_unit.sv
test/tb.sv
